// ----- design/ile_pkg.sv -----
package ile_pkg;

  // Field widths of the command and result words
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned LEN_W    = 9;

  // Default list capacity
  localparam int unsigned CAPACITY_DEF = 256;

  // Command opcodes
  localparam logic [OPCODE_W-1:0] OP_READ      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_HEAD  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_APPEND    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_INS_AT    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DELETE_AT = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic [DATA_W-1:0] data_t;

endpackage

// ----- design/indexed_list_engine.sv -----
// Ordered list of up to CAPACITY signed 32-bit values kept packed in one
// single-port-read, single-port-write synchronous memory. A command word is
// taken when start is high and busy is low; busy stays high until its result
// word has been issued, and each command yields exactly one result word on
// the out_ ports, flagged by out_valid for one cycle (there is no back
// pressure, so the receiver must take it then). A read out of range, a
// rejected command, an unused opcode, a delete of the last entry or an
// insert that needs no shifting shows its result in the next cycle; a
// read in range passes through the registered memory read and the S_RDW
// state before its result is registered. An insert at position p moves
// count-p entries and a delete at position p moves count-p-1 entries.
// The shift rate of one entry per cycle is set by the memory having one
// read and one write port.
// The memory content is not cleared at reset; only entries below the current
// length are ever read, and all of those have been written.
module indexed_list_engine #(
  parameter int unsigned CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ile_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [ile_pkg::POS_W-1:0]    in_position,
  input  logic signed [ile_pkg::DATA_W-1:0] in_data_in,
  output logic                         out_valid,
  output logic signed [ile_pkg::DATA_W-1:0] out_read_value,
  output logic [ile_pkg::STAT_W-1:0]   out_status,
  output logic [ile_pkg::LEN_W-1:0]    out_length
);
  import ile_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RDW   = 2'd1;
  localparam logic [1:0] S_MOVE  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  // List storage
  data_t mem [CAPACITY];
  data_t rd_data_r;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  data_t         wr_data;

  // Control and payload registers
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wb_addr_r, wb_addr_nxt;
  logic          pend_r, pend_nxt;
  logic          up_r, up_nxt;
  logic [AW-1:0] ins_addr_r, ins_addr_nxt;
  data_t         data_r, data_nxt;

  logic              out_valid_r, out_valid_nxt;
  data_t             out_value_r, out_value_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [LEN_W-1:0]  out_length_r, out_length_nxt;

  // Widened views for comparisons
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] cnt_inc_ext;
  logic [CMPW-1:0] cnt_dec_ext;
  logic [CMPW-1:0] ins_pos;
  logic [CMPW-1:0] ins_moves;
  logic [CMPW-1:0] del_moves;
  logic            full;
  logic            accept;

  assign accept      = start && (state_r == S_IDLE);
  assign pos_ext     = CMPW'(in_position);
  assign cnt_ext     = CMPW'(count_r);
  assign cnt_inc_ext = cnt_ext + CMPW'(1);
  assign cnt_dec_ext = cnt_ext - CMPW'(1);
  assign full        = (count_r == CW'(CAPACITY));
  assign del_moves   = cnt_ext - pos_ext - CMPW'(1);
  assign ins_moves   = cnt_ext - ins_pos;

  // Pick the slot the new word lands in
  always_comb begin
    case (in_opcode)
      OP_INS_HEAD: ins_pos = '0;
      OP_APPEND:   ins_pos = cnt_ext;
      default:     ins_pos = pos_ext;
    endcase
  end

  // Sequence commands and drive the memory ports
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    rd_ptr_nxt     = rd_ptr_r;
    wb_addr_nxt    = wb_addr_r;
    pend_nxt       = 1'b0;
    up_nxt         = up_r;
    ins_addr_nxt   = ins_addr_r;
    data_nxt       = data_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_length_nxt = out_length_r;
    rd_en          = 1'b0;
    rd_addr        = rd_ptr_r;
    wr_en          = 1'b0;
    wr_addr        = wb_addr_r;
    wr_data        = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_value_nxt  = '0;
          out_status_nxt = ST_OK;
          out_length_nxt = cnt_ext[LEN_W-1:0];
          case (in_opcode)
            OP_READ: begin
              if (pos_ext < cnt_ext) begin
                rd_en     = 1'b1;
                rd_addr   = pos_ext[AW-1:0];
                state_nxt = S_RDW;
              end else begin
                out_value_nxt  = '1;
                out_status_nxt = ST_RANGE;
                out_valid_nxt  = 1'b1;
              end
            end
            OP_INS_HEAD, OP_APPEND, OP_INS_AT: begin
              if ((in_opcode == OP_INS_AT) && (pos_ext > cnt_ext)) begin
                out_status_nxt = ST_RANGE;
                out_valid_nxt  = 1'b1;
              end else if (full) begin
                out_status_nxt = ST_FULL;
                out_valid_nxt  = 1'b1;
              end else if (ins_moves == '0) begin
                // nothing to shift: store at the tail now
                wr_en          = 1'b1;
                wr_addr        = ins_pos[AW-1:0];
                wr_data        = in_data_in;
                count_nxt      = count_r + CW'(1);
                out_length_nxt = cnt_inc_ext[LEN_W-1:0];
                out_valid_nxt  = 1'b1;
              end else begin
                up_nxt       = 1'b1;
                n_nxt        = ins_moves[CW-1:0];
                rd_ptr_nxt   = cnt_dec_ext[AW-1:0];
                ins_addr_nxt = ins_pos[AW-1:0];
                data_nxt     = in_data_in;
                state_nxt    = S_MOVE;
              end
            end
            OP_DELETE_AT: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = ST_RANGE;
                out_valid_nxt  = 1'b1;
              end else if (del_moves == '0) begin
                count_nxt      = count_r - CW'(1);
                out_length_nxt = cnt_dec_ext[LEN_W-1:0];
                out_valid_nxt  = 1'b1;
              end else begin
                up_nxt     = 1'b0;
                n_nxt      = del_moves[CW-1:0];
                rd_ptr_nxt = pos_ext[AW-1:0] + AW'(1);
                state_nxt  = S_MOVE;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_RDW: begin
        out_value_nxt = rd_data_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_MOVE: begin
        // write back the word read last cycle one slot over
        wr_en = pend_r;
        if (n_r != '0) begin
          rd_en       = 1'b1;
          rd_addr     = rd_ptr_r;
          pend_nxt    = 1'b1;
          wb_addr_nxt = up_r ? (rd_ptr_r + AW'(1)) : (rd_ptr_r - AW'(1));
          rd_ptr_nxt  = up_r ? (rd_ptr_r - AW'(1)) : (rd_ptr_r + AW'(1));
          n_nxt       = n_r - CW'(1);
        end else if (up_r) begin
          state_nxt = S_WRITE;
        end else begin
          count_nxt      = count_r - CW'(1);
          out_length_nxt = cnt_dec_ext[LEN_W-1:0];
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_WRITE: begin
        // drop the new word into the opened gap
        wr_en          = 1'b1;
        wr_addr        = ins_addr_r;
        wr_data        = data_r;
        count_nxt      = count_r + CW'(1);
        out_length_nxt = cnt_inc_ext[LEN_W-1:0];
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    wb_addr_r    <= wb_addr_nxt;
    up_r         <= up_nxt;
    ins_addr_r   <= ins_addr_nxt;
    data_r       <= data_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_length_r <= out_length_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;
  assign out_length     = out_length_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result word issued while a command is still running");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> full)
    else $error("full status with room left");

  a_move_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MOVE) && (n_r == '0)) |-> pend_r)
    else $error("shift finished without a pending write-back");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_valid_r)
    else $error("length changed without a result word");
`endif

endmodule
